// ===== src/rsr_pkg.sv =====
package rsr_pkg;

    localparam int QDEPTH = 2;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] BASE_RETRY_RST = 8'd5;
    localparam logic [7:0] MAX_RETRY_RST  = 8'd60;

    // opcodes
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_LINK  = 3'd2;
    localparam logic [2:0] OP_HSHK  = 3'd3;
    localparam logic [2:0] OP_REG   = 3'd4;
    localparam logic [2:0] OP_SUB   = 3'd5;
    localparam logic [2:0] OP_TICK  = 3'd6;

    // server reply kinds
    localparam logic [1:0] RK_OK    = 2'd0;
    localparam logic [1:0] RK_ERR   = 2'd1;
    localparam logic [1:0] RK_DATA  = 2'd2;

    // actions
    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_OPEN = 3'd1;
    localparam logic [2:0] ACT_SEND = 3'd2;
    localparam logic [2:0] ACT_REG  = 3'd3;
    localparam logic [2:0] ACT_SUB  = 3'd4;
    localparam logic [2:0] ACT_FWD  = 3'd5;
    localparam logic [2:0] ACT_ARM  = 3'd6;

    // session phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_CONN = 3'd1;
    localparam logic [2:0] PH_HSHK = 3'd2;
    localparam logic [2:0] PH_REG  = 3'd3;
    localparam logic [2:0] PH_SUB  = 3'd4;
    localparam logic [2:0] PH_RUN  = 3'd5;
    localparam logic [2:0] PH_WAIT = 3'd6;

    // config register indexes
    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_MAX  = 2'd1;
    localparam logic [1:0] CFG_DV2  = 2'd2;
    localparam logic [1:0] CFG_DCH  = 2'd3;

    // event classes
    localparam logic [2:0] EV_START = 3'd0;
    localparam logic [2:0] EV_STOP  = 3'd1;
    localparam logic [2:0] EV_LINK  = 3'd2;
    localparam logic [2:0] EV_HSHK  = 3'd3;
    localparam logic [2:0] EV_REG   = 3'd4;
    localparam logic [2:0] EV_SUB   = 3'd5;
    localparam logic [2:0] EV_TICK  = 3'd6;
    localparam logic [2:0] EV_NOP   = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic       link_up;
        logic       open_ok;
        logic       hs_ok;
        logic       peer_v2;
        logic       peer_ch;
        logic       rep_ok;
        logic       rep_err;
        logic       rep_data;
    } t_evt;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_qctl;

endpackage

// ===== src/relay_session_retry_fsm.sv =====
// Relay uplink session controller. Events enter on the input channel, are
// classified and queued in a two-entry queue, and are executed by a
// state update that writes one result per event into an output register.
// Sustained rate is one event per clock while the output is not stalled; an
// accepted event is written into the queue, then popped when the output
// register is free or being taken, and its result is loaded into that register.
// The input stalls only while the queue holds two events. Configuration writes
// are always ready and registered; version and chunked writes apply only while halted.
module relay_session_retry_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic        i_link_connected,
    input  logic        i_open_ok,
    input  logic        i_data_present,
    input  logic        i_verify_ok,
    input  logic        i_peer_version2,
    input  logic        i_peer_chunked,
    input  logic [1:0]  i_reply_kind,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_action,
    output logic        o_release_link,
    output logic        o_do_unsubscribe,
    output logic        o_do_withdraw,
    output logic [2:0]  o_session_state,
    output logic [7:0]  o_retry_seconds,
    output logic        o_use_version2,
    output logic        o_use_chunked
);

    rsr_pkg::t_evt  front_evt;
    rsr_pkg::t_evt  q_evt;
    rsr_pkg::t_qctl qctl;
    logic           q_valid;
    logic           q_pop;
    logic           q_full;
    logic           back_ready;

    rsr_front u_front (
        .i_opcode         (i_opcode),
        .i_link_connected (i_link_connected),
        .i_open_ok        (i_open_ok),
        .i_data_present   (i_data_present),
        .i_verify_ok      (i_verify_ok),
        .i_peer_version2  (i_peer_version2),
        .i_peer_chunked   (i_peer_chunked),
        .i_reply_kind     (i_reply_kind),
        .o_evt            (front_evt)
    );

    rsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_evt   (front_evt),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_evt   (q_evt),
        .o_valid (q_valid)
    );

    assign q_pop       = q_valid && back_ready;
    assign qctl        = {q_valid, q_pop};
    assign o_in_stall  = q_full;
    assign o_cfg_ready = 1'b1;

    rsr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q              (qctl),
        .i_evt            (q_evt),
        .o_ready          (back_ready),
        .i_cfg_wr         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_action         (o_action),
        .o_release_link   (o_release_link),
        .o_do_unsubscribe (o_do_unsubscribe),
        .o_do_withdraw    (o_do_withdraw),
        .o_session_state  (o_session_state),
        .o_retry_seconds  (o_retry_seconds),
        .o_use_version2   (o_use_version2),
        .o_use_chunked    (o_use_chunked)
    );

endmodule

// ===== src/rsr_front.sv =====
module rsr_front (
    input  logic [2:0]      i_opcode,
    input  logic            i_link_connected,
    input  logic            i_open_ok,
    input  logic            i_data_present,
    input  logic            i_verify_ok,
    input  logic            i_peer_version2,
    input  logic            i_peer_chunked,
    input  logic [1:0]      i_reply_kind,
    output rsr_pkg::t_evt   o_evt
);

    always_comb begin
        o_evt.link_up  = i_link_connected;
        o_evt.open_ok  = i_open_ok;
        o_evt.hs_ok    = i_data_present & i_verify_ok;
        o_evt.peer_v2  = i_peer_version2;
        o_evt.peer_ch  = i_peer_chunked;
        o_evt.rep_ok   = (i_reply_kind == rsr_pkg::RK_OK);
        o_evt.rep_err  = (i_reply_kind == rsr_pkg::RK_ERR);
        o_evt.rep_data = (i_reply_kind == rsr_pkg::RK_DATA);
        case (i_opcode)
            rsr_pkg::OP_START: o_evt.kind = rsr_pkg::EV_START;
            rsr_pkg::OP_STOP:  o_evt.kind = rsr_pkg::EV_STOP;
            rsr_pkg::OP_LINK:  o_evt.kind = rsr_pkg::EV_LINK;
            rsr_pkg::OP_HSHK:  o_evt.kind = rsr_pkg::EV_HSHK;
            rsr_pkg::OP_REG:   o_evt.kind = rsr_pkg::EV_REG;
            rsr_pkg::OP_SUB:   o_evt.kind = rsr_pkg::EV_SUB;
            rsr_pkg::OP_TICK:  o_evt.kind = rsr_pkg::EV_TICK;
            default:           o_evt.kind = rsr_pkg::EV_NOP;
        endcase
    end

endmodule

// ===== src/rsr_queue.sv =====
module rsr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rsr_pkg::t_evt   i_evt,
    output logic            o_full,
    input  logic            i_pop,
    output rsr_pkg::t_evt   o_evt,
    output logic            o_valid
);

    rsr_pkg::t_evt                  r_mem [rsr_pkg::QDEPTH];
    logic [rsr_pkg::QIDX_W-1:0]     r_wr;
    logic [rsr_pkg::QIDX_W-1:0]     r_rd;
    logic [rsr_pkg::QCNT_W-1:0]     r_cnt;
    logic [rsr_pkg::QIDX_W-1:0]     n_wr;
    logic [rsr_pkg::QIDX_W-1:0]     n_rd;
    logic [rsr_pkg::QCNT_W-1:0]     n_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_full  = (r_cnt == rsr_pkg::QCNT_W'(rsr_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_evt   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == rsr_pkg::QIDX_W'(rsr_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == rsr_pkg::QIDX_W'(rsr_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

endmodule

// ===== src/rsr_back.sv =====
module rsr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsr_pkg::t_qctl  i_q,
    input  rsr_pkg::t_evt   i_evt,
    output logic            o_ready,
    input  logic            i_cfg_wr,
    input  logic [1:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [2:0]      o_action,
    output logic            o_release_link,
    output logic            o_do_unsubscribe,
    output logic            o_do_withdraw,
    output logic [2:0]      o_session_state,
    output logic [7:0]      o_retry_seconds,
    output logic            o_use_version2,
    output logic            o_use_chunked
);

    logic [7:0] r_base, r_max;

    logic [2:0] r_phase, n_phase;
    logic       r_halted, n_halted;
    logic [7:0] r_next_delay, n_next_delay;
    logic [7:0] r_countdown, n_countdown;
    logic       r_has_link, n_has_link;
    logic       r_is_reg, n_is_reg;
    logic       r_is_sub, n_is_sub;
    logic       r_mode_v2, n_mode_v2;
    logic       r_mode_ch, n_mode_ch;

    logic       r_out_valid;
    logic [2:0] r_o_action, n_o_action;
    logic       r_o_release, n_o_release;
    logic       r_o_unsub, n_o_unsub;
    logic       r_o_withdraw, n_o_withdraw;
    logic [7:0] r_o_retry, n_o_retry;
    logic [2:0] r_o_state;
    logic       r_o_v2, r_o_ch;

    logic       pop;
    logic       arm, open_req, teardown;
    logic [8:0] dbl;

    assign o_ready = !r_out_valid || !i_out_stall;
    assign pop     = i_q.pop;

    always_comb begin
        n_phase      = r_phase;
        n_halted     = r_halted;
        n_next_delay = r_next_delay;
        n_countdown  = r_countdown;
        n_has_link   = r_has_link;
        n_is_reg     = r_is_reg;
        n_is_sub     = r_is_sub;
        n_mode_v2    = r_mode_v2;
        n_mode_ch    = r_mode_ch;
        n_o_action   = rsr_pkg::ACT_NONE;
        n_o_release  = 1'b0;
        n_o_unsub    = 1'b0;
        n_o_withdraw = 1'b0;
        n_o_retry    = '0;
        arm          = 1'b0;
        open_req     = 1'b0;
        teardown     = 1'b0;
        dbl          = {r_next_delay, 1'b0};

        case (i_evt.kind)
            rsr_pkg::EV_START: begin
                n_halted = 1'b0;
                open_req = 1'b1;
            end
            rsr_pkg::EV_STOP: begin
                if (!r_halted) begin
                    n_halted = 1'b1;
                    teardown = 1'b1;
                    n_phase  = rsr_pkg::PH_IDLE;
                end
            end
            rsr_pkg::EV_LINK: begin
                if (!r_halted) begin
                    if (r_phase == rsr_pkg::PH_CONN && i_evt.link_up) begin
                        n_phase    = rsr_pkg::PH_HSHK;
                        n_o_action = rsr_pkg::ACT_SEND;
                    end else begin
                        arm = 1'b1;
                    end
                end
            end
            rsr_pkg::EV_HSHK: begin
                if (r_phase == rsr_pkg::PH_HSHK) begin
                    if (!i_evt.hs_ok) begin
                        arm = 1'b1;
                    end else begin
                        n_mode_v2  = i_evt.peer_v2;
                        n_mode_ch  = i_evt.peer_ch;
                        n_phase    = rsr_pkg::PH_REG;
                        n_o_action = rsr_pkg::ACT_REG;
                    end
                end
            end
            rsr_pkg::EV_REG: begin
                if (i_evt.rep_ok) begin
                    n_is_reg   = 1'b1;
                    n_phase    = rsr_pkg::PH_SUB;
                    n_o_action = rsr_pkg::ACT_SUB;
                end else if (i_evt.rep_err) begin
                    arm = 1'b1;
                end
            end
            rsr_pkg::EV_SUB: begin
                if (i_evt.rep_data) begin
                    if (r_phase == rsr_pkg::PH_RUN) begin
                        n_o_action = rsr_pkg::ACT_FWD;
                    end
                end else if (i_evt.rep_ok) begin
                    if (r_phase == rsr_pkg::PH_SUB) begin
                        n_is_sub     = 1'b1;
                        n_phase      = rsr_pkg::PH_RUN;
                        n_next_delay = r_base;
                    end
                end else if (i_evt.rep_err) begin
                    arm = 1'b1;
                end
            end
            rsr_pkg::EV_TICK: begin
                if (r_phase == rsr_pkg::PH_WAIT && !r_halted) begin
                    if (r_countdown <= 8'd1) begin
                        n_countdown = '0;
                        open_req    = 1'b1;
                    end else begin
                        n_countdown = r_countdown - 8'd1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (open_req && !n_halted) begin
            n_phase = rsr_pkg::PH_CONN;
            if (i_evt.open_ok) begin
                n_has_link = 1'b1;
                n_o_action = rsr_pkg::ACT_OPEN;
            end else begin
                n_has_link = 1'b0;
                arm        = 1'b1;
            end
        end

        if (arm && !n_halted) begin
            teardown     = 1'b1;
            n_phase      = rsr_pkg::PH_WAIT;
            n_countdown  = r_next_delay;
            n_o_retry    = r_next_delay;
            n_o_action   = rsr_pkg::ACT_ARM;
            n_next_delay = (dbl > {1'b0, r_max}) ? r_max : dbl[7:0];
        end

        if (teardown && n_has_link) begin
            n_o_release  = 1'b1;
            n_o_unsub    = n_is_sub;
            n_o_withdraw = n_is_reg;
            n_is_sub     = 1'b0;
            n_is_reg     = 1'b0;
            n_has_link   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= rsr_pkg::BASE_RETRY_RST;
            r_max        <= rsr_pkg::MAX_RETRY_RST;
            r_phase      <= rsr_pkg::PH_IDLE;
            r_halted     <= 1'b1;
            r_next_delay <= rsr_pkg::BASE_RETRY_RST;
            r_countdown  <= '0;
            r_has_link   <= 1'b0;
            r_is_reg     <= 1'b0;
            r_is_sub     <= 1'b0;
            r_mode_v2    <= 1'b0;
            r_mode_ch    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop) begin
                r_phase      <= n_phase;
                r_halted     <= n_halted;
                r_next_delay <= n_next_delay;
                r_countdown  <= n_countdown;
                r_has_link   <= n_has_link;
                r_is_reg     <= n_is_reg;
                r_is_sub     <= n_is_sub;
                r_mode_v2    <= n_mode_v2;
                r_mode_ch    <= n_mode_ch;
            end
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    rsr_pkg::CFG_BASE: begin
                        r_base <= i_cfg_data;
                        if (r_halted) begin
                            r_next_delay <= i_cfg_data;
                        end
                    end
                    rsr_pkg::CFG_MAX: r_max <= i_cfg_data;
                    rsr_pkg::CFG_DV2: begin
                        if (r_halted) begin
                            r_mode_v2 <= i_cfg_data[0];
                        end
                    end
                    rsr_pkg::CFG_DCH: begin
                        if (r_halted) begin
                            r_mode_ch <= i_cfg_data[0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register, loaded on every pop
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o_action   <= n_o_action;
            r_o_release  <= n_o_release;
            r_o_unsub    <= n_o_unsub;
            r_o_withdraw <= n_o_withdraw;
            r_o_retry    <= n_o_retry;
            r_o_state    <= n_phase;
            r_o_v2       <= n_mode_v2;
            r_o_ch       <= n_mode_ch;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_o_action;
    assign o_release_link   = r_o_release;
    assign o_do_unsubscribe = r_o_unsub;
    assign o_do_withdraw    = r_o_withdraw;
    assign o_session_state  = r_o_state;
    assign o_retry_seconds  = r_o_retry;
    assign o_use_version2   = r_o_v2;
    assign o_use_chunked    = r_o_ch;

    a_cleanup_needs_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_o_unsub || r_o_withdraw) |-> r_o_release)
        else $error("cleanup flag without link release");

    a_retry_only_on_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_o_action != rsr_pkg::ACT_ARM) |-> (r_o_retry == 8'd0))
        else $error("retry delay reported without arm action");

    a_delay_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && arm && !n_halted |=> (r_next_delay <= r_max))
        else $error("doubled retry delay exceeds cap");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> i_q.valid && o_ready)
        else $error("event popped without queue entry or result space");

endmodule
